// ===== hdl/tple_pkg.sv =====
package tple_pkg;

   localparam int MUL_W  = 29;
   localparam int PROD_W = 2 * MUL_W;

   typedef enum logic [1:0] {
      OP_TICK     = 2'd0,
      OP_NOTE_ON  = 2'd1,
      OP_SET_FX   = 2'd2,
      OP_NOTE_OFF = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      FX_ARP     = 3'd0,
      FX_GLIDE   = 3'd1,
      FX_VIBRATO = 3'd2,
      FX_SLIDE   = 3'd3
   } fx_kind_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DECODE,
      ST_GLIDE_DIV,
      ST_GLIDE_FIX,
      ST_GLIDE_STEP,
      ST_VIB_INC,
      ST_VIB_PHASE,
      ST_VIB_ROM,
      ST_VIB_SCALE,
      ST_VIB_RECIP,
      ST_FINISH
   } state_type;

   localparam logic [23:0] PHASE_STEP_RESET = 24'd89478;
   localparam logic [15:0] LEVEL_FULL       = 16'd32768;

   // glide step = floor((mag*speed + 1275) / 2550)
   localparam logic [23:0] GLIDE_ROUND      = 24'd1275;
   localparam logic [11:0] GLIDE_DIV        = 12'd2550;
   localparam logic [12:0] RECIP_2550       = 13'd6579;
   localparam logic [16:0] GLIDE_MIN_MAG    = 17'd2;

   // floor(n/3) = (n * ceil(2^30/3)) >> 30, exact for n < 2^29
   localparam logic [28:0] RECIP_3          = 29'd357913942;

   // vibrato term = floor((|s|*depth + 1920) / 3840), done as /256 then /15
   localparam logic [18:0] VIB_ROUND        = 19'd1920;
   localparam logic [12:0] RECIP_15         = 13'd4369;
   localparam logic [11:0] VIB_DIV          = 12'd15;

   localparam logic [63:0] HALF_PI_Q30      = 64'd1686629713;

   // sine of a quarter-cycle fraction (Q30, 0..2^30) in Q1.15
   function automatic logic [16:0] sine_quarter(input logic [30:0] frac);
      logic [63:0]        x;
      logic [63:0]        x2;
      logic [63:0]        t;
      logic signed [63:0] sum;
      logic [63:0]        r;
      x   = (64'(frac) * HALF_PI_Q30) >> 30;
      x2  = (x * x) >> 30;
      t   = x;
      sum = signed'(x);
      for (int k = 1; k <= 5; k++) begin
         t = ((t * x2) >> 30) / 64'((2 * k) * (2 * k + 1));
         if (k[0]) begin
            sum = sum - signed'(t);
         end else begin
            sum = sum + signed'(t);
         end
      end
      if (sum < 0) begin
         sum = '0;
      end
      r = (unsigned'(sum) + 64'd16384) >> 15;
      if (r > 64'd32768) begin
         r = 64'd32768;
      end
      return r[16:0];
   endfunction

   // level change per tick for a slide magnitude
   function automatic logic [9:0] slide_delta(input logic [3:0] mag);
      logic [31:0] num;
      num = 32'(mag) * 32'd32768 + 32'd500;
      return 10'(num / 32'd1000);
   endfunction

endpackage

// ===== hdl/tple_mult.sv =====
module tple_mult (
   input  logic                          clock,
   input  logic [tple_pkg::MUL_W-1:0]    mul_a,
   input  logic [tple_pkg::MUL_W-1:0]    mul_b,
   output logic [tple_pkg::PROD_W-1:0]   prod_ff
);

   always_ff @(posedge clock) begin
      prod_ff <= tple_pkg::PROD_W'(mul_a) * tple_pkg::PROD_W'(mul_b);
   end

endmodule

// ===== hdl/tple_sine_rom.sv =====
module tple_sine_rom #(
   parameter  int SINE_TABLE_DEPTH = 256,
   localparam int PH_L  = $clog2(SINE_TABLE_DEPTH),
   localparam int QTR   = SINE_TABLE_DEPTH / 4,
   localparam int AW    = $clog2(QTR + 1),
   localparam int SHIFT = 32 - PH_L
) (
   input  logic          clock,
   input  logic [AW-1:0] rd_addr,
   output logic [16:0]   rd_data_ff
);

   logic [16:0] sine_tab [QTR+1];

   for (genvar g = 0; g <= QTR; g++) begin : g_tab
      assign sine_tab[g] = tple_pkg::sine_quarter(31'(g << SHIFT));
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= sine_tab[rd_addr];
   end

endmodule

// ===== hdl/tracker_pitch_level_effects.sv =====
// channel | dir | beat contents
// req     | in  | tuser: operation, fx_type; tdata: note, velocity, fx_value, target_pitch
// rsp     | out | tdata: note_offset, level, voice_active
// csr     | in  | phase_step_per_hz, written with csr_wr_en
//
// A tick runs decode, the glide and vibrato steps and finish; other operations commit in decode.
// The tick time is set by the sequencer stepping one shared 29x29 multiplier through the
// glide product and divide, the vibrato phase increment and the vibrato scale and divide, one product per cycle.
// Synchronous active-high reset clears all voice state and loads the phase step default.
// req_tready is high only while idle; a result waiting on rsp does not block the next accept,
// but the sequencer holds its final step until the output register is free.
module tracker_pitch_level_effects #(
   parameter int ARP_PERIOD       = 6,
   parameter int SINE_TABLE_DEPTH = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // note[6:0], velocity[22:7], fx_value[30:23], target_pitch[46:31], zero[47]
   input  logic [47:0] req_tdata,
   // operation[1:0], fx_type[4:2]
   input  logic [4:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // note_offset[15:0], level[31:16], voice_active[32], zero[39:33]
   output logic [39:0] rsp_tdata,
   input  logic        csr_wr_en,
   input  logic [23:0] csr_wr_data
);

   localparam int CNT_W  = $clog2(ARP_PERIOD + 1);
   localparam int PH_L   = $clog2(SINE_TABLE_DEPTH);
   localparam int QTR    = SINE_TABLE_DEPTH / 4;
   localparam int ROM_AW = $clog2(QTR + 1);
   localparam int J_W    = PH_L - 2;

   tple_pkg::state_type   state_ff, state_in;
   tple_pkg::op_type      op_ff, op_in;
   tple_pkg::fx_kind_type fx_ff, fx_in;
   logic [6:0]            note_ff, note_in;
   logic [15:0]           vel_ff, vel_in;
   logic [7:0]            fxv_ff, fxv_in;
   logic signed [15:0]    target_ff, target_in;

   logic [23:0]           psph_ff, psph_in;
   logic                  active_ff, active_in;
   logic [6:0]            held_note_ff, held_note_in;
   logic [3:0]            arp_hi_ff, arp_hi_in;
   logic [3:0]            arp_lo_ff, arp_lo_in;
   logic [1:0]            arp_pos_ff, arp_pos_in;
   logic [CNT_W-1:0]      arp_cnt_ff, arp_cnt_in;
   logic [7:0]            speed_ff, speed_in;
   logic [3:0]            vib_rate_ff, vib_rate_in;
   logic [3:0]            vib_depth_ff, vib_depth_in;
   logic [4:0]            slide_ff, slide_in;
   logic [31:0]           phase_ff, phase_in;
   logic signed [15:0]    glide_ff, glide_in;
   logic signed [15:0]    base_ff, base_in;
   logic [15:0]           level_ff, level_in;

   logic                  glide_en_ff, glide_en_in;
   logic                  glide_neg_ff, glide_neg_in;
   logic [23:0]           glide_num_ff, glide_num_in;
   logic [12:0]           glide_q0_ff, glide_q0_in;
   logic [10:0]           vib_v_ff, vib_v_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [15:0]           rsp_offset_ff, rsp_offset_in;
   logic [15:0]           rsp_level_ff, rsp_level_in;
   logic                  rsp_active_ff, rsp_active_in;

   logic                  out_free;
   logic                  commit;
   logic [tple_pkg::MUL_W-1:0]  mul_a;
   logic [tple_pkg::MUL_W-1:0]  mul_b;
   logic [tple_pkg::PROD_W-1:0] prod_ff;
   logic [ROM_AW-1:0]     rom_addr;
   logic [J_W-1:0]        rom_j;
   logic [16:0]           rom_data_ff;
   logic [9:0]            slide_lut [16];

   // arpeggio
   logic                  arp_on;
   logic [CNT_W-1:0]      arp_cnt_inc;
   logic                  arp_wrap;
   logic [1:0]            arp_pos_nx;
   logic [15:0]           arp_base;

   // portamento
   logic signed [16:0]    glide_diff;
   logic [16:0]           glide_mag;
   logic                  glide_go;
   logic [23:0]           glide_num;
   logic [12:0]           glide_q0;
   logic [23:0]           glide_rem;
   logic [12:0]           glide_step;
   logic signed [15:0]    glide_next;
   logic signed [17:0]    glide_rel;
   logic signed [15:0]    glide_base;

   // vibrato
   logic [27:0]           vib_inc;
   logic [10:0]           vib_v;
   logic [7:0]            vib_q0;
   logic [11:0]           vib_q0x15;
   logic [11:0]           vib_rem;
   logic [7:0]            vib_mag;
   logic signed [8:0]     vib_term;
   logic signed [16:0]    out_sum;
   logic signed [15:0]    out_offset;

   // volume slide
   logic [3:0]            slide_mag;
   logic signed [17:0]    slide_sum;
   logic [15:0]           slide_level;

   tple_mult u_mult (
      .clock   (clock),
      .mul_a   (mul_a),
      .mul_b   (mul_b),
      .prod_ff (prod_ff)
   );

   tple_sine_rom #(
      .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
   ) u_sine_rom (
      .clock      (clock),
      .rd_addr    (rom_addr),
      .rd_data_ff (rom_data_ff)
   );

   for (genvar g = 0; g < 16; g++) begin : g_slide
      assign slide_lut[g] = tple_pkg::slide_delta(4'(g));
   end

   assign out_free   = ~rsp_valid_ff | rsp_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, rsp_active_ff, rsp_level_ff, rsp_offset_ff};

   // arpeggio
   assign arp_on      = (arp_hi_ff != 4'd0) || (arp_lo_ff != 4'd0);
   assign arp_cnt_inc = arp_cnt_ff + CNT_W'(1);
   assign arp_wrap    = arp_cnt_inc >= CNT_W'(ARP_PERIOD);

   always_comb begin
      arp_pos_nx = arp_pos_ff;
      if (arp_wrap) begin
         arp_pos_nx = (arp_pos_ff == 2'd2) ? 2'd0 : arp_pos_ff + 2'd1;
      end
      case (arp_pos_nx)
         2'd0: arp_base = 16'd0;
         2'd1: arp_base = {4'd0, arp_hi_ff, 8'd0};
         default: arp_base = {4'd0, arp_lo_ff, 8'd0};
      endcase
   end

   // portamento
   assign glide_diff = {target_ff[15], target_ff} - {glide_ff[15], glide_ff};
   assign glide_mag  = glide_diff[16] ? 17'(-glide_diff) : 17'(glide_diff);
   assign glide_go   = (speed_ff != 8'd0) && (glide_mag > tple_pkg::GLIDE_MIN_MAG);
   assign glide_num  = prod_ff[23:0] + tple_pkg::GLIDE_ROUND;
   assign glide_q0   = prod_ff[36:24];
   assign glide_rem  = glide_num_ff - prod_ff[23:0];
   assign glide_step = glide_q0_ff + 13'(glide_rem >= 24'(tple_pkg::GLIDE_DIV));
   assign glide_next = glide_neg_ff ? glide_ff - {3'd0, glide_step}
                                    : glide_ff + {3'd0, glide_step};
   assign glide_rel  = {{2{glide_next[15]}}, glide_next} - {3'd0, held_note_ff, 8'd0};

   always_comb begin
      if (glide_rel > 18'sd32767) begin
         glide_base = 16'sh7FFF;
      end else if (glide_rel < -18'sd32768) begin
         glide_base = 16'sh8000;
      end else begin
         glide_base = glide_rel[15:0];
      end
   end

   // vibrato
   assign rom_j     = phase_ff[29 -: J_W];
   assign rom_addr  = phase_ff[30] ? ROM_AW'(QTR) - ROM_AW'(rom_j) : ROM_AW'(rom_j);
   assign vib_inc   = prod_ff[57:30];
   assign vib_v     = 11'((prod_ff[18:0] + tple_pkg::VIB_ROUND) >> 8);
   assign vib_q0    = prod_ff[23:16];
   assign vib_q0x15 = {vib_q0, 4'd0} - {4'd0, vib_q0};
   assign vib_rem   = {1'b0, vib_v_ff} - vib_q0x15;
   assign vib_mag   = vib_q0 + 8'(vib_rem >= tple_pkg::VIB_DIV);

   always_comb begin
      vib_term = 9'sd0;
      if (vib_depth_ff != 4'd0) begin
         vib_term = phase_ff[31] ? -$signed({1'b0, vib_mag}) : $signed({1'b0, vib_mag});
      end
      out_sum = {base_ff[15], base_ff} + {{8{vib_term[8]}}, vib_term};
      if (out_sum > 17'sd32767) begin
         out_offset = 16'sh7FFF;
      end else if (out_sum < -17'sd32768) begin
         out_offset = 16'sh8000;
      end else begin
         out_offset = out_sum[15:0];
      end
   end

   // volume slide
   assign slide_mag = slide_ff[4] ? 4'(-slide_ff) : slide_ff[3:0];
   assign slide_sum = slide_ff[4] ? {2'd0, level_ff} - {8'd0, slide_lut[slide_mag]}
                                  : {2'd0, level_ff} + {8'd0, slide_lut[slide_mag]};

   always_comb begin
      if (slide_sum[17]) begin
         slide_level = 16'd0;
      end else if (slide_sum > 18'sd32768) begin
         slide_level = tple_pkg::LEVEL_FULL;
      end else begin
         slide_level = slide_sum[15:0];
      end
   end

   // sequencer: next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         tple_pkg::ST_IDLE: begin
            if (req_tvalid) state_in = tple_pkg::ST_DECODE;
         end
         tple_pkg::ST_DECODE: begin
            if (op_ff == tple_pkg::OP_TICK) begin
               state_in = tple_pkg::ST_GLIDE_DIV;
            end else if (out_free) begin
               state_in = tple_pkg::ST_IDLE;
            end
         end
         tple_pkg::ST_GLIDE_DIV:  state_in = tple_pkg::ST_GLIDE_FIX;
         tple_pkg::ST_GLIDE_FIX:  state_in = tple_pkg::ST_GLIDE_STEP;
         tple_pkg::ST_GLIDE_STEP: state_in = tple_pkg::ST_VIB_INC;
         tple_pkg::ST_VIB_INC:    state_in = tple_pkg::ST_VIB_PHASE;
         tple_pkg::ST_VIB_PHASE:  state_in = tple_pkg::ST_VIB_ROM;
         tple_pkg::ST_VIB_ROM:    state_in = tple_pkg::ST_VIB_SCALE;
         tple_pkg::ST_VIB_SCALE:  state_in = tple_pkg::ST_VIB_RECIP;
         tple_pkg::ST_VIB_RECIP:  state_in = tple_pkg::ST_FINISH;
         tple_pkg::ST_FINISH: begin
            if (out_free) state_in = tple_pkg::ST_IDLE;
         end
         default: state_in = tple_pkg::ST_IDLE;
      endcase
   end

   // sequencer: outputs and multiplier operands
   always_comb begin
      req_tready = 1'b0;
      commit     = 1'b0;
      mul_a      = '0;
      mul_b      = '0;
      case (state_ff)
         tple_pkg::ST_IDLE: req_tready = 1'b1;
         tple_pkg::ST_DECODE: begin
            commit = (op_ff != tple_pkg::OP_TICK) && out_free;
            mul_a  = tple_pkg::MUL_W'(glide_mag[15:0]);
            mul_b  = tple_pkg::MUL_W'(speed_ff);
         end
         tple_pkg::ST_GLIDE_DIV: begin
            mul_a = tple_pkg::MUL_W'(glide_num);
            mul_b = tple_pkg::MUL_W'(tple_pkg::RECIP_2550);
         end
         tple_pkg::ST_GLIDE_FIX: begin
            mul_a = tple_pkg::MUL_W'(glide_q0);
            mul_b = tple_pkg::MUL_W'(tple_pkg::GLIDE_DIV);
         end
         tple_pkg::ST_GLIDE_STEP: begin
            mul_a = tple_pkg::MUL_W'(vib_rate_ff);
            mul_b = tple_pkg::MUL_W'(psph_ff);
         end
         tple_pkg::ST_VIB_INC: begin
            mul_a = tple_pkg::MUL_W'({prod_ff[27:0], 1'b0});
            mul_b = tple_pkg::RECIP_3;
         end
         tple_pkg::ST_VIB_SCALE: begin
            mul_a = tple_pkg::MUL_W'(rom_data_ff);
            mul_b = tple_pkg::MUL_W'(vib_depth_ff);
         end
         tple_pkg::ST_VIB_RECIP: begin
            mul_a = tple_pkg::MUL_W'(vib_v);
            mul_b = tple_pkg::MUL_W'(tple_pkg::RECIP_15);
         end
         tple_pkg::ST_FINISH: begin
            commit = out_free;
            mul_a  = tple_pkg::MUL_W'(vib_v_ff);
            mul_b  = tple_pkg::MUL_W'(tple_pkg::RECIP_15);
         end
         default: ;
      endcase
   end

   // datapath next values
   always_comb begin
      op_in         = op_ff;
      fx_in         = fx_ff;
      note_in       = note_ff;
      vel_in        = vel_ff;
      fxv_in        = fxv_ff;
      target_in     = target_ff;
      psph_in       = psph_ff;
      active_in     = active_ff;
      held_note_in  = held_note_ff;
      arp_hi_in     = arp_hi_ff;
      arp_lo_in     = arp_lo_ff;
      arp_pos_in    = arp_pos_ff;
      arp_cnt_in    = arp_cnt_ff;
      speed_in      = speed_ff;
      vib_rate_in   = vib_rate_ff;
      vib_depth_in  = vib_depth_ff;
      slide_in      = slide_ff;
      phase_in      = phase_ff;
      glide_in      = glide_ff;
      base_in       = base_ff;
      level_in      = level_ff;
      glide_en_in   = glide_en_ff;
      glide_neg_in  = glide_neg_ff;
      glide_num_in  = glide_num_ff;
      glide_q0_in   = glide_q0_ff;
      vib_v_in      = vib_v_ff;
      rsp_valid_in  = rsp_valid_ff & ~rsp_tready;
      rsp_offset_in = rsp_offset_ff;
      rsp_level_in  = rsp_level_ff;
      rsp_active_in = rsp_active_ff;

      if (csr_wr_en) psph_in = csr_wr_data;

      case (state_ff)
         tple_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               op_in     = tple_pkg::op_type'(req_tuser[1:0]);
               fx_in     = tple_pkg::fx_kind_type'(req_tuser[4:2]);
               note_in   = req_tdata[6:0];
               vel_in    = req_tdata[22:7];
               fxv_in    = req_tdata[30:23];
               target_in = req_tdata[46:31];
            end
         end
         tple_pkg::ST_DECODE: begin
            if (op_ff == tple_pkg::OP_TICK) begin
               if (arp_on) begin
                  arp_cnt_in = arp_wrap ? '0 : arp_cnt_inc;
                  arp_pos_in = arp_pos_nx;
                  base_in    = arp_base;
               end
               if (slide_ff != 5'd0) level_in = slide_level;
               glide_en_in  = glide_go;
               glide_neg_in = glide_diff[16];
            end else if (commit) begin
               case (op_ff)
                  tple_pkg::OP_NOTE_ON: begin
                     active_in    = 1'b1;
                     held_note_in = note_ff;
                     base_in      = 16'sd0;
                     level_in     = (vel_ff > tple_pkg::LEVEL_FULL) ? tple_pkg::LEVEL_FULL
                                                                     : vel_ff;
                  end
                  tple_pkg::OP_NOTE_OFF: active_in = 1'b0;
                  tple_pkg::OP_SET_FX: begin
                     case (fx_ff)
                        tple_pkg::FX_ARP: begin
                           arp_hi_in  = fxv_ff[7:4];
                           arp_lo_in  = fxv_ff[3:0];
                           arp_pos_in = 2'd0;
                           arp_cnt_in = '0;
                        end
                        tple_pkg::FX_GLIDE: speed_in = fxv_ff;
                        tple_pkg::FX_VIBRATO: begin
                           vib_rate_in  = fxv_ff[7:4];
                           vib_depth_in = fxv_ff[3:0];
                        end
                        tple_pkg::FX_SLIDE: slide_in = {1'b0, fxv_ff[7:4]} - {1'b0, fxv_ff[3:0]};
                        default: ;
                     endcase
                  end
                  default: ;
               endcase
               rsp_valid_in  = 1'b1;
               rsp_offset_in = base_in;
               rsp_level_in  = level_in;
               rsp_active_in = active_in;
            end
         end
         tple_pkg::ST_GLIDE_DIV: glide_num_in = glide_num;
         tple_pkg::ST_GLIDE_FIX: glide_q0_in = glide_q0;
         tple_pkg::ST_GLIDE_STEP: begin
            if (glide_en_ff) begin
               glide_in = glide_next;
               base_in  = glide_base;
            end
         end
         tple_pkg::ST_VIB_PHASE: begin
            if (vib_depth_ff != 4'd0) phase_in = phase_ff + 32'(vib_inc);
         end
         tple_pkg::ST_VIB_RECIP: vib_v_in = vib_v;
         tple_pkg::ST_FINISH: begin
            if (commit) begin
               rsp_valid_in  = 1'b1;
               rsp_offset_in = out_offset;
               rsp_level_in  = level_ff;
               rsp_active_in = active_ff;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tple_pkg::ST_IDLE;
         psph_ff      <= tple_pkg::PHASE_STEP_RESET;
         active_ff    <= 1'b0;
         held_note_ff <= '0;
         arp_hi_ff    <= '0;
         arp_lo_ff    <= '0;
         arp_pos_ff   <= '0;
         arp_cnt_ff   <= '0;
         speed_ff     <= '0;
         vib_rate_ff  <= '0;
         vib_depth_ff <= '0;
         slide_ff     <= '0;
         phase_ff     <= '0;
         glide_ff     <= '0;
         base_ff      <= '0;
         level_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         psph_ff      <= psph_in;
         active_ff    <= active_in;
         held_note_ff <= held_note_in;
         arp_hi_ff    <= arp_hi_in;
         arp_lo_ff    <= arp_lo_in;
         arp_pos_ff   <= arp_pos_in;
         arp_cnt_ff   <= arp_cnt_in;
         speed_ff     <= speed_in;
         vib_rate_ff  <= vib_rate_in;
         vib_depth_ff <= vib_depth_in;
         slide_ff     <= slide_in;
         phase_ff     <= phase_in;
         glide_ff     <= glide_in;
         base_ff      <= base_in;
         level_ff     <= level_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      fx_ff         <= fx_in;
      note_ff       <= note_in;
      vel_ff        <= vel_in;
      fxv_ff        <= fxv_in;
      target_ff     <= target_in;
      glide_en_ff   <= glide_en_in;
      glide_neg_ff  <= glide_neg_in;
      glide_num_ff  <= glide_num_in;
      glide_q0_ff   <= glide_q0_in;
      vib_v_ff      <= vib_v_in;
      rsp_offset_ff <= rsp_offset_in;
      rsp_level_ff  <= rsp_level_in;
      rsp_active_ff <= rsp_active_in;
   end

   a_accept_decode: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> state_ff == tple_pkg::ST_DECODE)
      else $error("accepted beat did not enter decode");

   a_level_bound: assert property (@(posedge clock) disable iff (reset)
      level_ff <= tple_pkg::LEVEL_FULL)
      else $error("level above full scale");

   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == tple_pkg::ST_DECODE ||
                              $past(state_ff) == tple_pkg::ST_FINISH)
      else $error("result loaded outside decode or finish");

   a_arp_range: assert property (@(posedge clock) disable iff (reset)
      arp_cnt_ff < CNT_W'(ARP_PERIOD) && arp_pos_ff != 2'd3)
      else $error("arpeggio counter or position out of range");

endmodule

// ===== tb/tb_tracker_pitch_level_effects.sv =====
module tb_tracker_pitch_level_effects;
   import tple_pkg::*;

   localparam int ARP_TICKS    = 6;
   localparam int SETTLE       = 24;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int PHASE_ITEMS  = 120;
   localparam int MAX_REPORTS  = 30;
   localparam logic [2:0] FX_RESERVED = 3'd4;

   typedef struct {
      op_type             op;
      logic [6:0]         note;
      logic [15:0]        velocity;
      logic [2:0]         fx;
      logic [7:0]         fx_value;
      logic signed [15:0] target;
   } voice_cmd_t;

   typedef struct {
      logic signed [15:0] offset;
      logic [15:0]        level;
      logic               active;
   } voice_out_t;

   typedef struct {
      voice_cmd_t cmd;
      bit         known;
      voice_out_t want;
   } script_row_t;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   // note[6:0], velocity[22:7], fx_value[30:23], target_pitch[46:31], zero[47]
   logic [47:0] req_tdata;
   // operation[1:0], fx_type[4:2]
   logic [4:0]  req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   // note_offset[15:0], level[31:16], voice_active[32], zero[39:33]
   logic [39:0] rsp_tdata;
   logic        csr_wr_en;
   logic [23:0] csr_wr_data;

   tracker_pitch_level_effects dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // voice state mirror
   logic [23:0]        phase_per_hz = PHASE_STEP_RESET;
   logic               voice_on     = 1'b0;
   logic [6:0]         voice_note   = '0;
   logic [3:0]         arp_hi       = '0;
   logic [3:0]         arp_lo       = '0;
   int                 arp_pos      = 0;
   int                 arp_ticks    = 0;
   logic [7:0]         glide_rate   = '0;
   logic [3:0]         vib_rate     = '0;
   logic [3:0]         vib_depth    = '0;
   int                 slide_amt    = 0;
   logic [31:0]        vib_acc      = '0;
   int                 glide_q      = 0;
   int                 base_q       = 0;
   int                 level_q      = 0;

   voice_out_t         pending_q[$];
   script_row_t        script[$];
   voice_out_t         no_value;
   logic signed [15:0] aim_pitch    = '0;
   int                 send_pct     = 0;
   int                 stall_pct    = 0;
   int                 mismatches   = 0;
   int                 checked      = 0;
   int                 sent         = 0;
   int                 ticks_sent   = 0;
   int                 cycle_count  = 0;

   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d beats pending", cycle_count, pending_q.size());
         $display("tb_tracker_pitch_level_effects NOT OK");
         $finish;
      end
   end

   task automatic note_mismatch(input string what, input int got, input int want);
      if (mismatches < MAX_REPORTS) begin
         $display("mismatch @%0d beat %0d: %s got %0d want %0d",
                  cycle_count, checked, what, got, want);
      end
      mismatches++;
   endtask

   function automatic int clip_q88(input int v);
      if (v > 32767) begin
         return 32767;
      end
      if (v < -32768) begin
         return -32768;
      end
      return v;
   endfunction

   // sine of idx/256 of a full wave in Q1.15, Taylor series over a quarter wave in Q30
   function automatic int sine_at_index(input logic [7:0] idx);
      longint unsigned frac;
      longint unsigned x;
      longint unsigned x2;
      longint unsigned term;
      longint unsigned div;
      longint          acc;
      int              mag;
      frac = {idx[5:0], 24'd0};
      if (idx[6]) begin
         frac = (64'd1 << 30) - frac;
      end
      x    = (frac * 64'd1686629713) >> 30;
      x2   = (x * x) >> 30;
      term = x;
      acc  = longint'(x);
      for (int k = 1; k <= 5; k++) begin
         div  = 64'((2 * k) * (2 * k + 1));
         term = ((term * x2) >> 30) / div;
         if (k % 2 == 1) begin
            acc = acc - longint'(term);
         end else begin
            acc = acc + longint'(term);
         end
      end
      if (acc < 0) begin
         acc = 0;
      end
      mag = int'((acc + 16384) >>> 15);
      if (mag > 32768) begin
         mag = 32768;
      end
      return idx[7] ? -mag : mag;
   endfunction

   function automatic voice_out_t advance_voice(input voice_cmd_t c);
      voice_out_t      o;
      int              d;
      int              mag;
      int              step;
      int              s;
      int              m;
      int              vib;
      int              dl;
      longint unsigned inc;
      vib = 0;
      case (c.op)
         OP_NOTE_ON: begin
            voice_on   = 1'b1;
            voice_note = c.note;
            base_q     = 0;
            level_q    = (c.velocity > LEVEL_FULL) ? 32768 : int'(c.velocity);
         end
         OP_NOTE_OFF: begin
            voice_on = 1'b0;
         end
         OP_SET_FX: begin
            case (c.fx)
               FX_ARP: begin
                  arp_hi    = c.fx_value[7:4];
                  arp_lo    = c.fx_value[3:0];
                  arp_pos   = 0;
                  arp_ticks = 0;
               end
               FX_GLIDE: begin
                  glide_rate = c.fx_value;
               end
               FX_VIBRATO: begin
                  vib_rate  = c.fx_value[7:4];
                  vib_depth = c.fx_value[3:0];
               end
               FX_SLIDE: begin
                  slide_amt = int'(c.fx_value[7:4]) - int'(c.fx_value[3:0]);
               end
               default: begin
               end
            endcase
         end
         default: begin
            if (arp_hi != 0 || arp_lo != 0) begin
               arp_ticks++;
               if (arp_ticks >= ARP_TICKS) begin
                  arp_ticks = 0;
                  arp_pos   = (arp_pos + 1) % 3;
               end
               if (arp_pos == 0) begin
                  base_q = 0;
               end else begin
                  base_q = 256 * int'((arp_pos == 1) ? arp_hi : arp_lo);
               end
            end
            d = int'(c.target) - glide_q;
            if (glide_rate != 0 && d != 0) begin
               mag = (d < 0) ? -d : d;
               if (mag * 100 > 256) begin
                  step    = (mag * int'(glide_rate) + 1275) / 2550;
                  glide_q = glide_q + ((d < 0) ? -step : step);
                  base_q  = clip_q88(glide_q - int'(voice_note) * 256);
               end
            end
            if (vib_depth != 0) begin
               inc     = (64'(vib_rate) * 64'd2 * 64'(phase_per_hz)) / 64'd3;
               vib_acc = vib_acc + inc[31:0];
               s       = sine_at_index(vib_acc[31:24]);
               m       = (((s < 0) ? -s : s) * int'(vib_depth) + 1920) / 3840;
               vib     = (s < 0) ? -m : m;
            end
            if (slide_amt != 0) begin
               dl      = (((slide_amt < 0) ? -slide_amt : slide_amt) * 32768 + 500) / 1000;
               level_q = level_q + ((slide_amt < 0) ? -dl : dl);
               if (level_q < 0) begin
                  level_q = 0;
               end
               if (level_q > 32768) begin
                  level_q = 32768;
               end
            end
         end
      endcase
      o.offset = 16'(clip_q88(base_q + vib));
      o.level  = 16'(level_q);
      o.active = voice_on;
      return o;
   endfunction

   function automatic voice_cmd_t random_cmd();
      voice_cmd_t c;
      int         pick;
      pick       = $urandom_range(99);
      c.note     = 7'($urandom);
      c.velocity = 16'($urandom);
      c.fx       = 3'($urandom);
      c.fx_value = 8'($urandom);
      c.target   = 16'($urandom);
      if ($urandom_range(99) < 70) begin
         c.velocity = 16'($urandom_range(32768));
      end
      // hold a glide target long enough for the glide to settle
      if ($urandom_range(99) < 6) begin
         if ($urandom_range(1) == 1) begin
            aim_pitch = 16'($urandom);
         end else begin
            aim_pitch = 16'(int'(c.note) * 256 + $urandom_range(1024) - 512);
         end
      end
      if ($urandom_range(99) < 85) begin
         c.target = aim_pitch;
      end
      if (pick < 58) begin
         c.op = OP_TICK;
      end else if (pick < 78) begin
         c.op = OP_SET_FX;
         if ($urandom_range(9) != 0) begin
            c.fx = 3'($urandom_range(3));
         end
         if (c.fx == FX_ARP && $urandom_range(2) == 0) begin
            c.fx_value = '0;
         end
      end else if (pick < 90) begin
         c.op = OP_NOTE_ON;
      end else begin
         c.op = OP_NOTE_OFF;
      end
      return c;
   endfunction

   task automatic add_row(input op_type op, input int note, input int vel,
                          input logic [2:0] fx, input int fxv, input int target,
                          input bit known, input int off, input int lvl, input bit act);
      script_row_t row;
      row.cmd.op          = op;
      row.cmd.note        = 7'(note);
      row.cmd.velocity    = 16'(vel);
      row.cmd.fx          = fx;
      row.cmd.fx_value    = 8'(fxv);
      row.cmd.target      = 16'(target);
      row.known           = known;
      row.want.offset     = 16'(off);
      row.want.level      = 16'(lvl);
      row.want.active     = act;
      script.push_back(row);
   endtask

   task automatic send_cmd(input voice_cmd_t c, input bit drain_first,
                           input bit known, input voice_out_t want);
      voice_out_t predicted;
      if (drain_first || (send_pct != 0 && $urandom_range(99) < send_pct)) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
         while (drain_first && pending_q.size() != 0) begin
            @(posedge clock);
         end
         while (send_pct != 0 && $urandom_range(99) < send_pct) begin
            @(posedge clock);
         end
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {1'b0, c.target, c.fx_value, c.velocity, c.note};
      req_tuser  <= {c.fx, c.op};
      do begin
         @(posedge clock);
      end while (!req_tready);
      predicted = advance_voice(c);
      pending_q.push_back(known ? want : predicted);
      sent++;
      if (c.op == OP_TICK) begin
         ticks_sent++;
      end
   endtask

   task automatic drain_and_hold();
      req_tvalid <= 1'b0;
      while (pending_q.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE) @(posedge clock);
   endtask

   always @(posedge clock) begin : rsp_side
      voice_out_t want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_q.size() == 0) begin
            note_mismatch("beat with nothing pending, note_offset", int'($signed(rsp_tdata[15:0])), 0);
         end else begin
            want = pending_q.pop_front();
            if (rsp_tdata[15:0] !== want.offset) begin
               note_mismatch("note_offset", int'($signed(rsp_tdata[15:0])), int'(want.offset));
            end
            if (rsp_tdata[31:16] !== want.level) begin
               note_mismatch("level", int'(rsp_tdata[31:16]), int'(want.level));
            end
            if (rsp_tdata[32] !== want.active) begin
               note_mismatch("voice_active", int'(rsp_tdata[32]), int'(want.active));
            end
            if (rsp_tdata[39:33] !== '0) begin
               note_mismatch("pad bits", int'(rsp_tdata[39:33]), 0);
            end
            checked++;
         end
      end
      rsp_tready <= (stall_pct == 0) || ($urandom_range(99) >= stall_pct);
   end

   initial begin
      logic [23:0] phase_settings[5];
      int          send_modes[5];
      int          stall_modes[5];
      voice_cmd_t  c;
      reset       <= 1'b1;
      req_tvalid  <= 1'b0;
      req_tdata   <= '0;
      req_tuser   <= '0;
      rsp_tready  <= 1'b0;
      csr_wr_en   <= 1'b0;
      csr_wr_data <= '0;
      no_value    = '{offset: '0, level: '0, active: 1'b0};
      phase_settings = '{24'd0, 24'hFFFFFF, 24'($urandom), PHASE_STEP_RESET,
                         24'($urandom_range(1, 4095))};
      send_modes  = '{0, 50, 0, 21, 0};
      stall_modes = '{0, 0, 50, 21, 0};

      add_row(OP_TICK,       0,   0,       FX_ARP,      0,     0, 1, 0, 0,     0);
      add_row(OP_NOTE_ON,  127, 16'hFFFF,  FX_ARP,      0,     0, 1, 0, 32768, 1);
      add_row(OP_NOTE_OFF,   0,   0,       FX_ARP,      0,     0, 1, 0, 32768, 0);
      add_row(OP_NOTE_ON,    0,   0,       FX_ARP,      0,     0, 1, 0, 0,     1);
      add_row(OP_SET_FX,     0,   0,       FX_RESERVED, 8'hFF, 0, 1, 0, 0,     1);
      add_row(OP_SET_FX,     0,   0,       FX_SLIDE,    8'hF0, 0, 1, 0, 0,     1);
      add_row(OP_TICK,       0,   0,       FX_ARP,      0,     0, 0, 0, 0,     0);
      add_row(OP_SET_FX,     0,   0,       FX_SLIDE,    8'h0F, 0, 0, 0, 0,     0);
      add_row(OP_TICK,       0,   0,       FX_ARP,      0,     0, 0, 0, 0,     0);
      add_row(OP_NOTE_ON,   60, 32768,     FX_ARP,      0,     0, 1, 0, 32768, 1);
      add_row(OP_SET_FX,     0,   0,       FX_ARP,      8'h47, 0, 0, 0, 0,     0);
      for (int i = 0; i < ARP_TICKS; i++) begin
         add_row(OP_TICK,    0,   0,       FX_ARP,      0,     0, 0, 0, 0,     0);
      end
      add_row(OP_SET_FX,     0,   0,       FX_ARP,      8'h00, 0, 0, 0, 0,     0);
      add_row(OP_SET_FX,     0,   0,       FX_GLIDE,    8'hFF, 0, 0, 0, 0,     0);
      add_row(OP_SET_FX,     0,   0,       FX_VIBRATO,  8'hFF, 0, 0, 0, 0,     0);
      add_row(OP_NOTE_ON,  127, 1000,      FX_ARP,      0,     0, 1, 0, 1000,  1);
      add_row(OP_TICK,       0,   0,       FX_ARP,      0, -32768, 0, 0, 0,    0);
      add_row(OP_TICK,       0,   0,       FX_ARP,      0, 32767, 0, 0, 0,     0);
      add_row(OP_NOTE_OFF,   0,   0,       FX_ARP,      0,     0, 0, 0, 0,     0);
      add_row(OP_TICK,       0,   0,       FX_ARP,      0, 32767, 0, 0, 0,     0);

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      foreach (script[i]) begin
         send_cmd(script[i].cmd, 1'b0, script[i].known, script[i].want);
      end

      for (int p = 0; p < 5; p++) begin
         drain_and_hold();
         send_pct    = send_modes[p];
         stall_pct   = stall_modes[p];
         csr_wr_en   <= 1'b1;
         csr_wr_data <= phase_settings[p];
         @(posedge clock);
         csr_wr_en   <= 1'b0;
         phase_per_hz = phase_settings[p];
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            c = random_cmd();
            // every 30th item of the last phase setting, hold the sender until every pending beat is back
            send_cmd(c, (p == 4) && (n % 30 == 29), 1'b0, no_value);
         end
      end

      drain_and_hold();
      $display("ran %0d items (%0d ticks) over 5 phase-step settings incl. 0 and full scale,",
               sent, ticks_sent);
      $display("  no idling, sender gaps, receiver stalls and both; %0d beats checked",
               checked);
      if (mismatches == 0) begin
         $display("tb_tracker_pitch_level_effects OK");
      end else begin
         $display("tb_tracker_pitch_level_effects NOT OK");
      end
      $finish;
   end

endmodule
